// ----- rtl/gte_pkg.sv -----
`timescale 1ns / 1ps

package gte_pkg;

	localparam int IN_W     = 18;
	localparam int LOG_FRAC = 24;
	localparam int LANES    = 3;
	localparam int IG_W     = 16;
	localparam int BYTE_W   = 8;

	// front stage + log steps + A + Y + K + exp steps + byte stage
	localparam int DEPTH = 1 + LOG_FRAC + 3 + LOG_FRAC + 1;

	localparam logic [IG_W-1:0] IG_RESET = 16'd1862;

	typedef enum logic [1:0] {
		FORCE_NONE,
		FORCE_ZERO,
		FORCE_FULL
	} force_t;

	typedef struct packed {
		logic en;
		logic [IG_W-1:0] ig;
	} lane_ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		for (int n = 0; n < 32; n++) begin
			b = 64'd1 << (62 - 2 * n);
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(2^-i) in Q30, rounded down step by step
	function automatic logic [31:0] root_c(input int i);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int j = 1; j <= i; j++)
			c = isqrt64(c << 30);
		return c[31:0];
	endfunction

endpackage

// ----- rtl/gte_lane.sv -----
`timescale 1ns / 1ps

module gte_lane #(
	parameter int SAMPLE_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  gte_pkg::lane_ctl_t            ctl,
	input  logic [gte_pkg::IN_W-1:0]      sample,
	output logic [gte_pkg::BYTE_W-1:0]    result
);

	localparam int LF  = gte_pkg::LOG_FRAC;
	localparam int MW  = gte_pkg::IN_W - 1;
	localparam int PW  = 5;
	localparam int AW  = 30;
	localparam int YW  = AW + gte_pkg::IG_W - 12 + 1;
	localparam int KW  = 6;
	localparam logic [24:0] ONE = 25'd1 << SAMPLE_FRAC_BITS;

	// front stage
	logic [MW-1:0]  m;
	logic [PW-1:0]  p;
	logic [47:0]    z_wide;
	gte_pkg::force_t frc;

	always_comb begin
		m = sample[MW-1:0];
		p = '0;
		for (int b = 0; b < MW; b++)
			if (m[b]) p = PW'(b);
		z_wide = {{(48-MW){1'b0}}, m} << (6'd30 - {1'b0, p});
		if (sample[gte_pkg::IN_W-1] || sample == '0)
			frc = gte_pkg::FORCE_ZERO;
		else if ({7'd0, sample} >= ONE)
			frc = gte_pkg::FORCE_FULL;
		else
			frc = gte_pkg::FORCE_NONE;
	end

	gte_pkg::force_t lf_s [0:LF];
	logic [30:0]     z_s  [0:LF];
	logic [LF-1:0]   fr_s [0:LF];
	logic [PW-1:0]   p_s  [0:LF];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			lf_s[0] <= frc;
			z_s[0]  <= z_wide[30:0];
			fr_s[0] <= '0;
			p_s[0]  <= p;
		end
	end

	// log2 fraction, one bit per stage by repeated squaring
	for (genvar j = 1; j <= LF; j++) begin : g_log
		logic [61:0] sq;
		logic [31:0] zn;
		assign sq = z_s[j-1] * z_s[j-1];
		assign zn = sq[61:30];
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				lf_s[j] <= lf_s[j-1];
				p_s[j]  <= p_s[j-1];
				z_s[j]  <= zn[31] ? zn[31:1] : zn[30:0];
				fr_s[j] <= {fr_s[j-1][LF-2:0], zn[31]};
			end
		end
	end

	// -log2(x) in Q24, then scaled by the exponent
	gte_pkg::force_t fa_s1, fy_s2;
	logic [AW-1:0]   a_s1;
	logic [YW-1:0]   y_s2;
	logic [AW+gte_pkg::IG_W-1:0] ay;
	logic [PW-1:0]   fp;

	assign fp = PW'(SAMPLE_FRAC_BITS) - p_s[LF];
	assign ay = a_s1 * ctl.ig + (AW+gte_pkg::IG_W)'(2048);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			fa_s1 <= lf_s[LF];
			a_s1  <= ({{(AW-PW){1'b0}}, fp} << LF) - {{(AW-LF){1'b0}}, fr_s[LF]};
			fy_s2 <= fa_s1;
			y_s2  <= {1'b0, ay[AW+gte_pkg::IG_W-1:12]};
		end
	end

	// split into integer shift and fraction for exp2
	logic [YW:0]   ky;
	logic [YW-LF:0] kk;
	logic [LF-1:0] f_c;
	gte_pkg::force_t fk_c;

	always_comb begin
		ky  = {1'b0, y_s2} + (YW+1)'((1 << LF) - 1);
		kk  = ky[YW:LF];
		f_c = LF'(-y_s2);
		fk_c = fy_s2;
		if (fy_s2 == gte_pkg::FORCE_NONE && kk > (YW-LF+1)'(40))
			fk_c = gte_pkg::FORCE_ZERO;
	end

	gte_pkg::force_t fe_s [0:LF];
	logic [KW-1:0]   k_s  [0:LF];
	logic [LF-1:0]   f_s  [0:LF];
	logic [30:0]     pr_s [0:LF];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			fe_s[0] <= fk_c;
			k_s[0]  <= kk[KW-1:0];
			f_s[0]  <= f_c;
			pr_s[0] <= 31'd1 << 30;
		end
	end

	// exp2 of the fraction: one root factor per stage
	for (genvar i = 1; i <= LF; i++) begin : g_exp
		localparam logic [31:0] C = gte_pkg::root_c(i);
		logic [62:0] pm;
		assign pm = pr_s[i-1] * C;
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				fe_s[i] <= fe_s[i-1];
				k_s[i]  <= k_s[i-1];
				f_s[i]  <= f_s[i-1];
				pr_s[i] <= f_s[i-1][LF-i] ? pm[60:30] : pr_s[i-1];
			end
		end
	end

	logic [30:0] v;
	logic [39:0] bs;
	logic [9:0]  bb;
	logic [gte_pkg::BYTE_W-1:0] byte_s4;

	always_comb begin
		v  = pr_s[LF] >> k_s[LF];
		bs = 40'd255 * {9'd0, v} + (40'd1 << 29);
		bb = bs[39:30];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (fe_s[LF])
				gte_pkg::FORCE_ZERO: byte_s4 <= '0;
				gte_pkg::FORCE_FULL: byte_s4 <= '1;
				default:             byte_s4 <= (bb > 10'd255) ? 8'd255 : bb[7:0];
			endcase
		end
	end

	assign result = byte_s4;

endmodule

// ----- rtl/gamma_encode_to_8bit.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   red/green/blue_linear, 18 bit signed
// out      from block out_valid / out_stall red/green/blue_byte, 8 bit
// cfg      to block   cfg_we                cfg_wdata, inverse gamma Q4.12
//
// One pixel per clock unless a stalled result holds the pipeline; 53 register
// stages, among them the 24 squaring stages of log2 and the 24 multiply stages
// of exp2 in each lane.
// arst_n clears the valid pipeline and loads inverse gamma with 1862.
// A stalled result freezes the whole pipeline; in_stall follows at once.

module gamma_encode_to_8bit #(
	parameter int SAMPLE_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [gte_pkg::IN_W-1:0]   red_linear,
	input  logic [gte_pkg::IN_W-1:0]   green_linear,
	input  logic [gte_pkg::IN_W-1:0]   blue_linear,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [gte_pkg::BYTE_W-1:0] red_byte,
	output logic [gte_pkg::BYTE_W-1:0] green_byte,
	output logic [gte_pkg::BYTE_W-1:0] blue_byte,
	input  logic                       cfg_we,
	input  logic [gte_pkg::IG_W-1:0]   cfg_wdata
);

	localparam int D = gte_pkg::DEPTH;

	logic [gte_pkg::IG_W-1:0] ig_q;
	logic [D-1:0]             vld_q;
	gte_pkg::lane_ctl_t       ctl;
	logic [gte_pkg::IN_W-1:0]   lin [0:gte_pkg::LANES-1];
	logic [gte_pkg::BYTE_W-1:0] res [0:gte_pkg::LANES-1];

	assign ctl.en = !(vld_q[D-1] && out_stall);
	assign ctl.ig = ig_q;
	assign in_stall  = !ctl.en;
	assign out_valid = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ig_q <= gte_pkg::IG_RESET;
		end else if (cfg_we) begin
			ig_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.en) begin
			vld_q <= {vld_q[D-2:0], in_valid};
		end
	end

	assign lin[0] = red_linear;
	assign lin[1] = green_linear;
	assign lin[2] = blue_linear;

	for (genvar l = 0; l < gte_pkg::LANES; l++) begin : g_lane
		gte_lane #(
			.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.sample (lin[l]),
			.result (res[l])
		);
	end

	assign red_byte   = res[0];
	assign green_byte = res[1];
	assign blue_byte  = res[2];

endmodule

// ----- rtl/gte_checker.sv -----
`timescale 1ns / 1ps

module gte_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [gte_pkg::BYTE_W-1:0] red_byte
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_byte))
		else $error("stalled item changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind gamma_encode_to_8bit gte_checker u_gte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red_byte  (red_byte)
);

// ----- tb/tb_gamma_encode_to_8bit.sv -----
`timescale 1ns / 1ps

module tb_gamma_encode_to_8bit;

	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		logic [gte_pkg::BYTE_W-1:0] r;
		logic [gte_pkg::BYTE_W-1:0] g;
		logic [gte_pkg::BYTE_W-1:0] b;
	} pixel_bytes_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [gte_pkg::IN_W-1:0] red_linear, green_linear, blue_linear;
	logic out_valid;
	logic out_stall;
	logic [gte_pkg::BYTE_W-1:0] red_byte, green_byte, blue_byte;
	logic cfg_we;
	logic [gte_pkg::IG_W-1:0] cfg_wdata;

	pixel_bytes_t encoded_q[$];
	logic [gte_pkg::IG_W-1:0] exponent_q412;
	logic [63:0] half_roots[0:gte_pkg::LOG_FRAC];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int errors;

	gamma_encode_to_8bit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red_linear(red_linear), .green_linear(green_linear), .blue_linear(blue_linear),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_byte(red_byte), .green_byte(green_byte), .blue_byte(blue_byte),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v, res, bitv;
		v = v_in;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// x^(ig/4096) via fixed-point log2, multiply, exp2
	function automatic logic [7:0] gamma_byte(input logic [gte_pkg::IN_W-1:0] s,
			input logic [gte_pkg::IG_W-1:0] ig);
		logic [63:0] z, frac, a, y, k, f, prod, v, b;
		int p;
		if (s[gte_pkg::IN_W-1] || s == 0)
			return 8'd0;
		if (s >= (1 << FRAC))
			return 8'd255;
		p = 0;
		while ((64'(s) >> (p + 1)) != 0)
			p++;
		z = 64'(s) << (30 - p);
		frac = 0;
		for (int i = 0; i < gte_pkg::LOG_FRAC; i++) begin
			z = (z * z) >> 30;
			frac = frac << 1;
			if (z >= (64'd2 << 30)) begin
				z = z >> 1;
				frac = frac | 64'd1;
			end
		end
		a = (64'(FRAC - p) << gte_pkg::LOG_FRAC) - frac;
		y = (a * 64'(ig) + 64'd2048) >> 12;
		k = (y + (64'd1 << gte_pkg::LOG_FRAC) - 1) >> gte_pkg::LOG_FRAC;
		f = (k << gte_pkg::LOG_FRAC) - y;
		if (k > 40)
			return 8'd0;
		prod = 64'd1 << 30;
		for (int i = 1; i <= gte_pkg::LOG_FRAC; i++)
			if (f[gte_pkg::LOG_FRAC-i])
				prod = (prod * half_roots[i]) >> 30;
		v = prod >> k;
		b = (64'd255 * v + (64'd1 << 29)) >> 30;
		if (b > 255)
			b = 255;
		return b[7:0];
	endfunction

	task automatic send_pixel(input logic [gte_pkg::IN_W-1:0] r,
			input logic [gte_pkg::IN_W-1:0] g, input logic [gte_pkg::IN_W-1:0] b);
		pixel_bytes_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_linear <= r;
		green_linear <= g;
		blue_linear <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		e.r = gamma_byte(r, exponent_q412);
		e.g = gamma_byte(g, exponent_q412);
		e.b = gamma_byte(b, exponent_q412);
		encoded_q.push_back(e);
	endtask

	task automatic drain;
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (encoded_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_exponent(input logic [gte_pkg::IG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		exponent_q412 = v;
	endtask

	function automatic logic [gte_pkg::IN_W-1:0] rand_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return gte_pkg::IN_W'(($urandom_range(1, 65535) >> $urandom_range(0, 15)) | 1);
		else if (sel < 75)
			return gte_pkg::IN_W'($urandom_range(65534, 65537));
		else
			return gte_pkg::IN_W'($urandom);
	endfunction

	task automatic test_directed;
		logic [gte_pkg::IN_W-1:0] v[$];
		v = '{18'h0, 18'h3ffff, 18'h20000, 18'h1ffff, 18'h10000, 18'h0ffff, 18'h1,
			18'h2, 18'h8000, 18'h4000, 18'h100, 18'h3, 18'h0fffe, 18'h10001, 18'h2aaaa,
			18'h15555};
		foreach (v[i])
			send_pixel(v[i], v[(i + 5) % v.size()], v[(i + 11) % v.size()]);
		drain();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(rand_sample(), rand_sample(), rand_sample());
		drain();
	endtask

	// receiver holds off long enough that the pipeline fills and in_stall rises
	task automatic test_backpressure;
		hold_req = 1;
		for (int i = 0; i < 120; i++)
			send_pixel(rand_sample(), rand_sample(), rand_sample());
		drain();
	endtask

	task automatic test_exponent_extremes;
		logic [gte_pkg::IG_W-1:0] settings[$];
		settings = '{16'd0, 16'd1, 16'd65535, 16'd4096, 16'd9011};
		foreach (settings[i]) begin
			write_exponent(settings[i]);
			test_directed();
			test_random(30);
		end
	endtask

	always @(posedge clk) begin
		pixel_bytes_t e;
		if (out_valid && !out_stall) begin
			if (encoded_q.size() == 0) begin
				$error("unexpected item: r=%0d g=%0d b=%0d", red_byte, green_byte, blue_byte);
				errors++;
			end else begin
				e = encoded_q.pop_front();
				if (red_byte !== e.r) begin
					$error("red_byte expected %0d actual %0d", e.r, red_byte);
					errors++;
				end
				if (green_byte !== e.g) begin
					$error("green_byte expected %0d actual %0d", e.g, green_byte);
					errors++;
				end
				if (blue_byte !== e.b) begin
					$error("blue_byte expected %0d actual %0d", e.b, blue_byte);
					errors++;
				end
			end
		end
	end

	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		half_roots[0] = 64'd2 << 30;
		for (int i = 1; i <= gte_pkg::LOG_FRAC; i++)
			half_roots[i] = int_sqrt(half_roots[i-1] << 30);
		errors = 0;
		hold_req = 0;
		send_idle_pct = 29;
		recv_idle_pct = 58;
		exponent_q412 = gte_pkg::IG_RESET;
		arst_n = 1'b0;
		in_valid = 1'b0;
		red_linear = '0;
		green_linear = '0;
		blue_linear = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(350);
		send_idle_pct = 58;
		recv_idle_pct = 29;
		write_exponent(16'd65535);
		test_random(350);
		test_exponent_extremes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_exponent(16'd1862);
		test_backpressure();
		test_random(484);
		drain();

		if (errors == 0 && encoded_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (encoded_q.size() != 0)
				$error("%0d expected items never arrived", encoded_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
